### design/gidx_pkg.sv
// ----------------------------------------------------------------------------
// gidx_pkg
// Shared types and constants of the grid index unmap block.
// ----------------------------------------------------------------------------
package gidx_pkg;

  localparam int unsigned DIM_BITS   = 10;
  localparam int unsigned INDEX_BITS = 30;
  localparam int unsigned DREG_W     = DIM_BITS + 1;
  localparam int unsigned COORD_W    = DIM_BITS + 2;
  localparam int unsigned STRIDE_W   = 2 * DREG_W;
  localparam int unsigned NUM_AXES   = 3;

  localparam logic [1:0] AXIS_MASK = 2'h3;

  // Item kinds.
  localparam logic ACT_UNMAP = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_DIM_X = 2'd0;
  localparam logic [1:0] REG_DIM_Y = 2'd1;
  localparam logic [1:0] REG_DIM_Z = 2'd2;
  localparam logic [1:0] REG_ORDER = 2'd3;

  typedef struct packed {
    logic                       action;
    logic [INDEX_BITS-1:0]      linear_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] out_x;
    logic [INDEX_BITS-1:0] out_y;
    logic [INDEX_BITS-1:0] out_z;
    logic                  inside_res;
    logic                  order_error;
  } out_item_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic                  unmap;
    logic                  in_grid;
    logic                  bad;
    logic [INDEX_BITS-1:0] idx;
  } task_t;

  // Strides sorted from largest to smallest, with the axis of each slot.
  typedef struct packed {
    logic [NUM_AXES-1:0][STRIDE_W-1:0] stride;
    logic [NUM_AXES-1:0][1:0]          axis;
  } plan_t;

  // One entry of the division pipeline.
  typedef struct packed {
    logic                                unmap;
    logic                                in_grid;
    logic                                bad;
    logic [INDEX_BITS-1:0]               rem;
    logic [NUM_AXES-1:0][INDEX_BITS-1:0] quo;
  } pipe_t;

endpackage

### design/grid_index_unmap_core.sv
// ----------------------------------------------------------------------------
// grid_index_unmap_core
// Linear voxel index to x, y, z with a configurable axis order.
// ----------------------------------------------------------------------------
// Items enter through push/full and results leave through empty/pop; each
// item gives exactly one result, in order. An item is an unmap of
// linear_index or an inside-grid check of coord_x/y/z.
// Grid sizes and the order code are written on the cfg channel (always
// ready); the user must write them only while the block is idle, which the
// block does not enforce. The sorted strides follow in the next cycle.
// Throughput is one item per cycle while the result queue can take results.
// An item passes from the input transfer through the input queue into the
// entry stage, through the three chained division pipelines of 30 stages
// each (one quotient bit per stage) and into the result queue.
// Reset empties both queues and the pipeline and loads sizes 1, 1, 1 and
// order code 36 (x fastest, then y, then z).
// When the receiver stops popping, the output queue fills and the whole
// division pipeline holds; the input queue then fills and full rises.
// ----------------------------------------------------------------------------
module grid_index_unmap_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  gidx_pkg::in_item_t  in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output gidx_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic [gidx_pkg::NUM_AXES-1:0][gidx_pkg::DREG_W-1:0] dim_q;
  logic [5:0]          order_q;
  gidx_pkg::task_t     task_in, task_out;
  gidx_pkg::plan_t     plan;
  logic                task_empty, task_pop;
  logic                res_full, res_push;
  gidx_pkg::out_item_t res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= {gidx_pkg::NUM_AXES{gidx_pkg::DREG_W'(1)}};
      order_q <= 6'd36;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gidx_pkg::REG_DIM_X: dim_q[0] <= cfg_data_i[gidx_pkg::DREG_W-1:0];
        gidx_pkg::REG_DIM_Y: dim_q[1] <= cfg_data_i[gidx_pkg::DREG_W-1:0];
        gidx_pkg::REG_DIM_Z: dim_q[2] <= cfg_data_i[gidx_pkg::DREG_W-1:0];
        gidx_pkg::REG_ORDER: order_q  <= cfg_data_i[5:0];
        default:             order_q  <= order_q;
      endcase
    end
  end

  gidx_front u_front (
    .clk_i, .rst_ni, .dim_i(dim_q), .order_i(order_q),
    .item_i(in_item_i), .task_o(task_in), .plan_o(plan)
  );

  // Short queue between classification and division.
  gidx_fifo #(.T(gidx_pkg::task_t), .DEPTH(2)) u_task_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(task_in), .full_o(full),
    .pop_i(task_pop), .data_o(task_out), .empty_o(task_empty)
  );

  gidx_back u_back (
    .clk_i, .rst_ni, .plan_i(plan), .task_empty_i(task_empty),
    .task_i(task_out), .task_pop_o(task_pop), .res_full_i(res_full),
    .res_push_o(res_push), .res_o(res)
  );

  // Result queue decouples the pipeline from the receiver.
  gidx_fifo #(.T(gidx_pkg::out_item_t), .DEPTH(2)) u_res_q (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );

endmodule

### design/gidx_fifo.sv
// ----------------------------------------------------------------------------
// gidx_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module gidx_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/gidx_front.sv
// ----------------------------------------------------------------------------
// gidx_front
// Classifies incoming items and derives the sorted stride plan.
// ----------------------------------------------------------------------------
module gidx_front (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [gidx_pkg::NUM_AXES-1:0][gidx_pkg::DREG_W-1:0] dim_i,
  input  logic [5:0]                                    order_i,
  input  gidx_pkg::in_item_t                            item_i,
  output gidx_pkg::task_t                               task_o,
  output gidx_pkg::plan_t                               plan_o
);

  logic [1:0] fa, ma, sa;
  logic       bad;
  logic       in_grid;
  logic [gidx_pkg::NUM_AXES-1:0][gidx_pkg::COORD_W-1:0] coord;
  logic [gidx_pkg::NUM_AXES-1:0][gidx_pkg::STRIDE_W-1:0] stride;
  logic [gidx_pkg::DREG_W-1:0]   dim_f, dim_m;
  logic [gidx_pkg::STRIDE_W-1:0] prod;
  gidx_pkg::plan_t plan_d, plan_q;

  function automatic logic [gidx_pkg::DREG_W-1:0] pick_dim(
    input logic [gidx_pkg::NUM_AXES-1:0][gidx_pkg::DREG_W-1:0] dims,
    input logic [1:0] ax
  );
    logic [gidx_pkg::DREG_W-1:0] r;
    case (ax)
      2'd0:    r = dims[0];
      2'd1:    r = dims[1];
      2'd2:    r = dims[2];
      default: r = '0;
    endcase
    return r;
  endfunction

  // Decode the order code and flag codes that are not a permutation.
  assign fa  = order_i[1:0] & gidx_pkg::AXIS_MASK;
  assign ma  = order_i[3:2] & gidx_pkg::AXIS_MASK;
  assign sa  = order_i[5:4] & gidx_pkg::AXIS_MASK;
  assign bad = (fa == 2'd3) || (ma == 2'd3) || (sa == 2'd3) ||
               (fa == ma) || (fa == sa) || (ma == sa);

  // Inside-grid check on the signed coordinates.
  assign coord[0] = item_i.coord_x;
  assign coord[1] = item_i.coord_y;
  assign coord[2] = item_i.coord_z;
  always_comb begin
    in_grid = 1'b1;
    for (int a = 0; a < gidx_pkg::NUM_AXES; a++) begin
      if (coord[a][gidx_pkg::COORD_W-1] ||
          (coord[a][gidx_pkg::DREG_W-1:0] >= dim_i[a])) begin
        in_grid = 1'b0;
      end
    end
  end

  always_comb begin
    task_o.unmap   = (item_i.action == gidx_pkg::ACT_UNMAP) && !bad;
    task_o.in_grid = (item_i.action == gidx_pkg::ACT_CHECK) && in_grid;
    task_o.bad     = bad;
    task_o.idx     = item_i.linear_index;
  end

  // Per-axis strides from the order code.
  assign dim_f = pick_dim(dim_i, fa);
  assign dim_m = pick_dim(dim_i, ma);
  assign prod  = dim_f * dim_m;
  always_comb begin
    for (int a = 0; a < gidx_pkg::NUM_AXES; a++) begin
      if (2'(a) == fa) begin
        stride[a] = gidx_pkg::STRIDE_W'(1);
      end else if (2'(a) == ma) begin
        stride[a] = gidx_pkg::STRIDE_W'(dim_f);
      end else if (2'(a) == sa) begin
        stride[a] = prod;
      end else begin
        stride[a] = '0;
      end
    end
  end

  // Rank each axis: larger strides first, ties to the lower axis number.
  always_comb begin
    logic [1:0] rank;
    plan_d = '0;
    for (int a = 0; a < gidx_pkg::NUM_AXES; a++) begin
      rank = '0;
      for (int b = 0; b < gidx_pkg::NUM_AXES; b++) begin
        if (b != a && ((stride[b] > stride[a]) ||
                       (stride[b] == stride[a] && b < a))) begin
          rank = rank + 1'b1;
        end
      end
      plan_d.stride[rank] = stride[a];
      plan_d.axis[rank]   = 2'(a);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q <= '0;
    end else begin
      plan_q <= plan_d;
    end
  end

  assign plan_o = plan_q;

endmodule

### design/gidx_div.sv
// ----------------------------------------------------------------------------
// gidx_div
// Pipelined restoring divider, one quotient bit per stage, for one slot.
// ----------------------------------------------------------------------------
module gidx_div #(
  parameter int unsigned SLOT = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [gidx_pkg::STRIDE_W-1:0]     divisor_i,
  input  logic                              valid_i,
  input  gidx_pkg::pipe_t                   data_i,
  output logic                              valid_o,
  output gidx_pkg::pipe_t                   data_o
);

  localparam int unsigned N = gidx_pkg::INDEX_BITS;

  logic            vld_q [N];
  gidx_pkg::pipe_t stg_q [N];
  gidx_pkg::pipe_t stg_d [N];
  logic [N-1:0]    dvs;

  // One restoring step on quotient bit sh.
  function automatic gidx_pkg::pipe_t div_step(
    input gidx_pkg::pipe_t cur,
    input int unsigned     sh,
    input logic [N-1:0]    d
  );
    gidx_pkg::pipe_t nxt;
    nxt = cur;
    if ((cur.rem >> sh) >= d) begin
      nxt.rem = cur.rem - (d << sh);
      nxt.quo[SLOT][sh] = 1'b1;
    end else begin
      nxt.quo[SLOT][sh] = 1'b0;
    end
    return nxt;
  endfunction

  assign dvs = N'(divisor_i);

  // Each stage resolves one quotient bit, most significant first.
  always_comb begin
    stg_d[0] = div_step(data_i, N - 1, dvs);
    for (int i = 1; i < N; i++) begin
      stg_d[i] = div_step(stg_q[i-1], N - 1 - i, dvs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < N; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  // A zero stride gives a zero coordinate; the remainder is already untouched.
  always_comb begin
    data_o = stg_q[N-1];
    if (divisor_i == '0) begin
      data_o.quo[SLOT] = '0;
    end
  end
  assign valid_o = vld_q[N-1];

endmodule

### design/gidx_back.sv
// ----------------------------------------------------------------------------
// gidx_back
// Runs the three chained divisions and assembles the result item.
// ----------------------------------------------------------------------------
module gidx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gidx_pkg::plan_t     plan_i,
  input  logic                task_empty_i,
  input  gidx_pkg::task_t     task_i,
  output logic                task_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output gidx_pkg::out_item_t res_o
);

  logic            en;
  logic            v0_q;
  gidx_pkg::pipe_t p0_q, p0_d;
  logic            v1, v2, v3;
  gidx_pkg::pipe_t p1, p2, p3;
  logic [gidx_pkg::NUM_AXES-1:0][gidx_pkg::INDEX_BITS-1:0] coord;

  // The whole pipeline holds only when a finished result cannot leave.
  assign en         = !(v3 && res_full_i);
  assign task_pop_o = en && !task_empty_i;
  assign res_push_o = v3 && !res_full_i;

  always_comb begin
    p0_d         = '0;
    p0_d.unmap   = task_i.unmap;
    p0_d.in_grid = task_i.in_grid;
    p0_d.bad     = task_i.bad;
    p0_d.rem     = task_i.idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= !task_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= p0_d;
    end
  end

  gidx_div #(.SLOT(0)) u_div0 (
    .clk_i, .rst_ni, .en_i(en), .divisor_i(plan_i.stride[0]),
    .valid_i(v0_q), .data_i(p0_q), .valid_o(v1), .data_o(p1)
  );
  gidx_div #(.SLOT(1)) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .divisor_i(plan_i.stride[1]),
    .valid_i(v1), .data_i(p1), .valid_o(v2), .data_o(p2)
  );
  gidx_div #(.SLOT(2)) u_div2 (
    .clk_i, .rst_ni, .en_i(en), .divisor_i(plan_i.stride[2]),
    .valid_i(v2), .data_i(p2), .valid_o(v3), .data_o(p3)
  );

  // Route each slot's quotient to its axis; non-unmap items give zeros.
  always_comb begin
    coord = '0;
    if (p3.unmap) begin
      for (int k = 0; k < gidx_pkg::NUM_AXES; k++) begin
        coord[plan_i.axis[k]] = p3.quo[k];
      end
    end
    res_o.out_x       = coord[0];
    res_o.out_y       = coord[1];
    res_o.out_z       = coord[2];
    res_o.inside_res  = p3.in_grid;
    res_o.order_error = p3.bad;
  end

endmodule

### design/gidx_checker.sv
// ----------------------------------------------------------------------------
// gidx_checker
// Port-level checks of the grid index unmap block, bound to the top level.
// ----------------------------------------------------------------------------
module gidx_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input gidx_pkg::out_item_t out_item_o
);

  // A waiting result stays until it is transferred.
  a_res_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result vanished without a transfer");

  // A stalled result keeps its payload.
  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_item_o))
    else $error("stalled result changed");

  // A check result that is inside carries zero coordinates.
  a_check_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.inside_res |->
      out_item_o.out_x == '0 && out_item_o.out_y == '0 && out_item_o.out_z == '0)
    else $error("check result with nonzero coordinates");

  // A bad order code yields zero coordinates.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.order_error |->
      out_item_o.out_x == '0 && out_item_o.out_y == '0 && out_item_o.out_z == '0)
    else $error("bad order code with nonzero coordinates");

endmodule

bind grid_index_unmap_core gidx_checker u_gidx_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .empty(empty), .pop(pop),
  .out_item_o(out_item_o)
);

### dv/grid_index_unmap_core_test.sv
// ----------------------------------------------------------------------------
// grid_index_unmap_core_test
// Self-checking bench for the grid index unmap core.
// ----------------------------------------------------------------------------
// A directed table covers reset defaults, field extremes, both item kinds and
// bad order codes. Random phases follow, each with its own grid sizes and
// order code. Every transfer out of the block is compared with a table result
// or with a coordinate predictor kept in step with the register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_index_unmap_core_test;

  localparam int DRAIN_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 20000;

  // One row of the directed table.
  typedef struct {
    gidx_pkg::in_item_t  item;
    bit                  known;
    gidx_pkg::out_item_t result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  gidx_pkg::in_item_t in_item_i = '0;
  logic full, empty;
  logic pop = 1'b0;
  gidx_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = gidx_pkg::REG_DIM_X;
  logic [31:0] cfg_data_i = '0;

  // Predictor copy of the registers.
  logic [gidx_pkg::DREG_W-1:0] grid_dim [3];
  logic [5:0] axis_order;

  gidx_pkg::out_item_t coords_pending[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit pop_enable = 1'b0;

  grid_index_unmap_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predict the result of one item under the current settings.
  function automatic gidx_pkg::out_item_t predict_coords(gidx_pkg::in_item_t it);
    gidx_pkg::out_item_t r;
    logic [1:0] fa, ma, sa;
    logic [63:0] stride [3];
    logic [63:0] rest;
    logic [63:0] q [3];
    bit used [3];
    int best;
    bit bad;
    r = '0;
    fa = axis_order[1:0];
    ma = axis_order[3:2];
    sa = axis_order[5:4];
    bad = fa == gidx_pkg::AXIS_MASK || ma == gidx_pkg::AXIS_MASK ||
          sa == gidx_pkg::AXIS_MASK || fa == ma || fa == sa || ma == sa;
    r.order_error = bad;
    q = '{64'd0, 64'd0, 64'd0};
    if (it.action == gidx_pkg::ACT_CHECK) begin
      r.inside_res = 1'b1;
      if (it.coord_x < 0 || it.coord_x >= $signed({1'b0, grid_dim[0]})) r.inside_res = 1'b0;
      if (it.coord_y < 0 || it.coord_y >= $signed({1'b0, grid_dim[1]})) r.inside_res = 1'b0;
      if (it.coord_z < 0 || it.coord_z >= $signed({1'b0, grid_dim[2]})) r.inside_res = 1'b0;
    end else if (!bad) begin
      used = '{0, 0, 0};
      rest = 64'(it.linear_index);
      stride[fa] = 64'd1;
      stride[ma] = 64'(grid_dim[fa]);
      stride[sa] = 64'(grid_dim[fa]) * 64'(grid_dim[ma]);
      for (int k = 0; k < 3; k++) begin
        best = -1;
        for (int a = 0; a < 3; a++) begin
          if (!used[a] && (best < 0 || stride[a] > stride[best])) best = a;
        end
        used[best] = 1'b1;
        if (stride[best] != 0) begin
          q[best] = rest / stride[best];
          rest = rest % stride[best];
        end
      end
    end
    r.out_x = q[0][gidx_pkg::INDEX_BITS-1:0];
    r.out_y = q[1][gidx_pkg::INDEX_BITS-1:0];
    r.out_z = q[2][gidx_pkg::INDEX_BITS-1:0];
    return r;
  endfunction

  function automatic gidx_pkg::in_item_t make_unmap(logic [gidx_pkg::INDEX_BITS-1:0] idx);
    gidx_pkg::in_item_t it;
    it = '0;
    it.action = gidx_pkg::ACT_UNMAP;
    it.linear_index = idx;
    return it;
  endfunction

  function automatic gidx_pkg::in_item_t make_check(int x, int y, int z);
    gidx_pkg::in_item_t it;
    it = '0;
    it.action = gidx_pkg::ACT_CHECK;
    it.coord_x = x[gidx_pkg::COORD_W-1:0];
    it.coord_y = y[gidx_pkg::COORD_W-1:0];
    it.coord_z = z[gidx_pkg::COORD_W-1:0];
    return it;
  endfunction

  function automatic gidx_pkg::in_item_t random_item();
    gidx_pkg::in_item_t it;
    logic [95:0] raw;
    logic [63:0] span;
    int unsigned pick;
    int cx, cy, cz;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(gidx_pkg::in_item_t)-1:0];
    span = 64'(grid_dim[0]) * 64'(grid_dim[1]) * 64'(grid_dim[2]) + 64'd2;
    // Mostly indices that land inside the grid, some anywhere.
    if (it.action == gidx_pkg::ACT_UNMAP && $urandom_range(3) != 0) begin
      pick = $urandom_range(span[31:0]);
      it.linear_index = pick[gidx_pkg::INDEX_BITS-1:0];
    end
    if (it.action == gidx_pkg::ACT_CHECK && $urandom_range(2) != 0) begin
      cx = int'($urandom_range(32'(grid_dim[0]) + 32'd1)) - 1;
      cy = int'($urandom_range(32'(grid_dim[1]) + 32'd1)) - 1;
      cz = int'($urandom_range(32'(grid_dim[2]) + 32'd1)) - 1;
      it.coord_x = cx[gidx_pkg::COORD_W-1:0];
      it.coord_y = cy[gidx_pkg::COORD_W-1:0];
      it.coord_z = cz[gidx_pkg::COORD_W-1:0];
    end
    return it;
  endfunction

  // Write one register and mirror it in the predictor.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gidx_pkg::REG_ORDER) axis_order = val[5:0];
    else grid_dim[idx] = val[gidx_pkg::DREG_W-1:0];
    // Let the sorted strides settle.
    repeat (3) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (coords_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Send one item with a bursty sender; gaps come before the transfer.
  task automatic send_item(gidx_pkg::in_item_t it, bit known, gidx_pkg::out_item_t res);
    if ($urandom_range(7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    coords_pending.push_back(known ? res : predict_coords(it));
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) send_item(random_item(), 1'b0, '0);
    push <= 1'b0;
    wait_drained();
  endtask

  // Receiver stall pattern and result checking.
  always @(posedge clk_i) begin
    gidx_pkg::out_item_t want;
    if (pop && !empty) begin
      if (coords_pending.size() == 0) begin
        $error("result with no expectation: %p", out_item_o);
        fail_count++;
      end else begin
        want = coords_pending.pop_front();
        if (out_item_o.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, out_item_o.out_x);
          fail_count++;
        end
        if (out_item_o.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, out_item_o.out_y);
          fail_count++;
        end
        if (out_item_o.out_z !== want.out_z) begin
          $error("out_z expected %0d actual %0d", want.out_z, out_item_o.out_z);
          fail_count++;
        end
        if (out_item_o.inside_res !== want.inside_res) begin
          $error("inside_res expected %0b actual %0b", want.inside_res,
                 out_item_o.inside_res);
          fail_count++;
        end
        if (out_item_o.order_error !== want.order_error) begin
          $error("order_error expected %0b actual %0b", want.order_error,
                 out_item_o.order_error);
          fail_count++;
        end
      end
    end
    if (!pop_enable) pop <= 1'b0;
    else if (($urandom_range(255) < 64) && (($urandom >> 3) % 4 != 0)) pop <= 1'b1;
    else pop <= ($urandom_range(3) != 0);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    gidx_pkg::out_item_t r;
    grid_dim = '{11'd1, 11'd1, 11'd1};
    axis_order = 6'd36;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    pop_enable = 1'b1;

    // Directed rows under reset settings (1x1x1 grid, x-y-z order).
    // All strides are equal there, so x takes the whole index.
    r = '0;
    rows.push_back('{make_unmap('0), 1'b1, r});
    r = '0; r.out_x = 30'h3FFFFFFF;
    rows.push_back('{make_unmap(30'h3FFFFFFF), 1'b1, r});
    r = '0; r.inside_res = 1'b1;
    rows.push_back('{make_check(0, 0, 0), 1'b1, r});
    r = '0;
    rows.push_back('{make_check(-2048, 0, 0), 1'b1, r});
    rows.push_back('{make_check(0, 2047, 0), 1'b1, r});
    rows.push_back('{make_check(0, 0, -1), 1'b1, r});
    rows.push_back('{make_check(1, 1, 1), 1'b1, r});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].result);
    push <= 1'b0;
    wait_drained();

    // Largest grid, then extremes of the index and coordinates.
    write_reg(gidx_pkg::REG_DIM_X, 32'd1024);
    write_reg(gidx_pkg::REG_DIM_Y, 32'd1024);
    write_reg(gidx_pkg::REG_DIM_Z, 32'd1024);
    write_reg(gidx_pkg::REG_ORDER, 32'b000110);
    rows.delete();
    rows.push_back('{make_unmap(30'h3FFFFFFF), 1'b0, '0});
    rows.push_back('{make_unmap(30'd1048575), 1'b0, '0});
    rows.push_back('{make_check(1023, 1023, 1023), 1'b0, '0});
    rows.push_back('{make_check(1024, 0, 0), 1'b0, '0});
    rows.push_back('{make_check(2047, -2048, -1), 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].result);
    push <= 1'b0;
    wait_drained();

    // Bad order codes: repeated axis and axis number 3.
    write_reg(gidx_pkg::REG_ORDER, 32'b111001);
    r = '0; r.order_error = 1'b1;
    send_item(make_unmap(30'd12345), 1'b1, r);
    push <= 1'b0;
    wait_drained();
    write_reg(gidx_pkg::REG_ORDER, 32'b000000);
    send_item(make_unmap(30'd7), 1'b1, r);
    r.inside_res = 1'b1;
    send_item(make_check(3, 3, 3), 1'b1, r);
    push <= 1'b0;
    wait_drained();

    // Zero and oversized dimensions.
    write_reg(gidx_pkg::REG_DIM_X, 32'd0);
    write_reg(gidx_pkg::REG_DIM_Y, 32'd2047);
    write_reg(gidx_pkg::REG_DIM_Z, 32'd5);
    write_reg(gidx_pkg::REG_ORDER, 32'b100100);
    run_phase(60);

    // Random phases with random settings, smaller grids mostly.
    for (int p = 0; p < 10; p++) begin
      write_reg(gidx_pkg::REG_DIM_X, (p == 0) ? 32'd1 : $urandom_range(40, 1));
      write_reg(gidx_pkg::REG_DIM_Y,
                $urandom_range(2047) & ((p % 3 == 0) ? 32'h7FF : 32'h3F));
      write_reg(gidx_pkg::REG_DIM_Z, $urandom_range(64, 1));
      write_reg(gidx_pkg::REG_ORDER, ($urandom_range(7) == 0) ? $urandom_range(63) :
                (p % 6 == 0 ? 32'd36 : p % 6 == 1 ? 32'd24 : p % 6 == 2 ? 32'd33 :
                 p % 6 == 3 ? 32'd9 : p % 6 == 4 ? 32'd18 : 32'd6));
      run_phase(90);
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
